// ----- design/tci_pkg.sv -----
// ----------------------------------------------------------------------------
// tci_pkg: shared definitions for the track cone isolation block
// Field widths, fixed-point constants, register indexes and CORDIC tables.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tci_pkg;

  // Number of CORDIC iterations for both the circular and hyperbolic passes.
  localparam int CORDIC_STEPS = 16;
  // Upper bound on the in-cone track count.
  localparam int MAX_TRACKS   = 1024;
  localparam int COUNT_CAP_I  = (MAX_TRACKS < 2047) ? MAX_TRACKS : 2047;

  // Field widths.
  localparam int MOM_W   = 16;
  localparam int SUM_W   = 40;
  localparam int CNT_W   = 11;
  localparam int DR_W    = 16;
  localparam int RAD_W   = 13;
  localparam int CFG_W   = 16;
  localparam int IDX_W   = 3;

  localparam logic [CNT_W-1:0] COUNT_CAP = CNT_W'(COUNT_CAP_I);

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_SUM_MODE       = 3'd0;
  localparam logic [IDX_W-1:0] REG_OUTER_RADIUS   = 3'd1;
  localparam logic [IDX_W-1:0] REG_INNER_RADIUS   = 3'd2;
  localparam logic [IDX_W-1:0] REG_COUNT_MIN_PT   = 3'd3;
  localparam logic [IDX_W-1:0] REG_CLOSEST_MIN_PT = 3'd4;
  localparam logic [IDX_W-1:0] REG_ISO_THRESHOLD  = 3'd5;

  // Sum mode codes.
  localparam logic [1:0] MODE_PLAIN    = 2'd0;
  localparam logic [1:0] MODE_REL      = 2'd1;
  localparam logic [1:0] MODE_SQ       = 2'd2;
  localparam logic [1:0] MODE_REL_SQ   = 2'd3;

  // Fixed-point constants (angles internally in 2^-16).
  localparam logic signed [21:0] PI_Z       = 22'sd205887;
  localparam logic [15:0]        LN2_Z      = 16'd45426;
  localparam logic signed [13:0] PHI_PI     = 14'sd3217;
  localparam logic signed [13:0] PHI_2PI    = 14'sd6434;
  localparam logic signed [25:0] ETA_MAX    = 26'sd8191;
  localparam logic signed [16:0] VZ_WINDOW  = 17'sd51;
  localparam logic [31:0]        MIN_SUM_SQ = 32'd4096;
  localparam logic [DR_W-1:0]    NO_DR      = 16'hFFFF;
  localparam logic [SUM_W-1:0]   SAT40      = 40'hFF_FFFF_FFFF;
  localparam logic [27:0]        SAT28      = 28'hFFF_FFFF;
  localparam logic [5:0]         K_MAX      = 6'd40;

  // Sequencer step limits.
  localparam logic [5:0] SQ_LAST     = 6'd5;
  localparam logic [5:0] DRSQ_LAST   = 6'd1;
  localparam logic [5:0] ROOT_LAST   = 6'd23;
  localparam logic [5:0] DIV_LAST    = 6'd55;
  localparam logic [5:0] CORDIC_LAST = 6'(CORDIC_STEPS - 1);

  // Circular arctangent table, 2^-16 units.
  function automatic logic [15:0] atan_lut(input logic [4:0] idx);
    logic [15:0] v;
    case (idx)
      5'd0:  v = 16'd51472;
      5'd1:  v = 16'd30385;
      5'd2:  v = 16'd16055;
      5'd3:  v = 16'd8150;
      5'd4:  v = 16'd4091;
      5'd5:  v = 16'd2047;
      5'd6:  v = 16'd1024;
      5'd7:  v = 16'd512;
      5'd8:  v = 16'd256;
      5'd9:  v = 16'd128;
      5'd10: v = 16'd64;
      5'd11: v = 16'd32;
      5'd12: v = 16'd16;
      5'd13: v = 16'd8;
      5'd14: v = 16'd4;
      5'd15: v = 16'd2;
      5'd16: v = 16'd1;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

  // Hyperbolic arctangent table, 2^-16 units.
  function automatic logic [15:0] atanh_lut(input logic [4:0] idx);
    logic [15:0] v;
    case (idx)
      5'd1:  v = 16'd35999;
      5'd2:  v = 16'd16739;
      5'd3:  v = 16'd8235;
      5'd4:  v = 16'd4101;
      5'd5:  v = 16'd2049;
      5'd6:  v = 16'd1024;
      5'd7:  v = 16'd512;
      5'd8:  v = 16'd256;
      5'd9:  v = 16'd128;
      5'd10: v = 16'd64;
      5'd11: v = 16'd32;
      5'd12: v = 16'd16;
      5'd13: v = 16'd8;
      5'd14: v = 16'd4;
      5'd15: v = 16'd2;
      5'd16: v = 16'd1;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- design/tci_if.sv -----
// ----------------------------------------------------------------------------
// tci_if: channel interfaces of the track cone isolation block
// Valid/ready channels for track items and isolation results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tci_in_if;
  logic                                valid;
  logic                                ready;
  logic                                operation;
  logic signed [tci_pkg::MOM_W-1:0]    mom_x;
  logic signed [tci_pkg::MOM_W-1:0]    mom_y;
  logic signed [tci_pkg::MOM_W-1:0]    mom_z;
  logic signed [tci_pkg::MOM_W-1:0]    vertex_z;
  logic                                last;

  modport source (output valid, operation, mom_x, mom_y, mom_z, vertex_z, last,
                  input ready);
  modport sink   (input valid, operation, mom_x, mom_y, mom_z, vertex_z, last,
                  output ready);
endinterface

interface tci_out_if;
  logic                          valid;
  logic                          ready;
  logic [tci_pkg::SUM_W-1:0]     pt_sum;
  logic [tci_pkg::CNT_W-1:0]     track_count;
  logic [tci_pkg::DR_W-1:0]      closest_dr;
  logic [tci_pkg::DR_W-1:0]      closest_dr_veto;
  logic                          isolated;

  modport source (output valid, pt_sum, track_count, closest_dr, closest_dr_veto,
                  isolated, input ready);
  modport sink   (input valid, pt_sum, track_count, closest_dr, closest_dr_veto,
                  isolated, output ready);
endinterface

// ----- design/track_cone_isolation_core.sv -----
// ----------------------------------------------------------------------------
// track_cone_isolation_core: tracker isolation cone around one electron
// Sequence per item: squares, two square roots, a doubling search, a
//   hyperbolic and a circular CORDIC pass, then eta and the cone compare;
//   a track inside the vertex window adds squares, a third root and the sum step;
//   a last track adds one division, two in relative squared mode.
// Throughput: one item at a time; a new item is taken only once the last
//   one is through. A result waits in the output register meanwhile.
// Reset: asynchronous, active low; control, configuration and accumulator registers
//   reset, datapath ones do not; the electron is all zero and distances read 65535.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module track_cone_isolation_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tci_pkg::IDX_W-1:0]      cfg_idx_i,
  input  logic [tci_pkg::CFG_W-1:0]      cfg_wdata_i,
  tci_in_if.sink                         in_i,
  tci_out_if.source                      out_o
);

  // The sequencer walks each item through a chain of steps. One
  // squarer, one digit-by-digit square root, one CORDIC datapath (circular
  // or hyperbolic) and one restoring divider are reused along the way.
  typedef enum logic [14:0] {
    ST_IDLE    = 15'b000000000000001,
    ST_SQR     = 15'b000000000000010,
    ST_ROOT_B  = 15'b000000000000100,
    ST_ROOT_A  = 15'b000000000001000,
    ST_KSRCH   = 15'b000000000010000,
    ST_HYP     = 15'b000000000100000,
    ST_CIRC    = 15'b000000001000000,
    ST_ETA     = 15'b000000010000000,
    ST_CMP     = 15'b000000100000000,
    ST_DRSQ    = 15'b000001000000000,
    ST_ROOT_DR = 15'b000010000000000,
    ST_ACC     = 15'b000100000000000,
    ST_DSET    = 15'b001000000000000,
    ST_DIV     = 15'b010000000000000,
    ST_OUT     = 15'b100000000000000
  } state_e;

  state_e      state_q, state_d;
  logic [5:0]  cnt_q, cnt_d;

  // Configuration registers.
  logic [1:0]  sum_mode_q;
  logic [12:0] outer_radius_q, inner_radius_q;
  logic [15:0] count_min_pt_q, closest_min_pt_q, iso_threshold_q;

  // Electron and accumulators.
  logic [15:0]        lead_pt_q;
  logic signed [13:0] lead_eta_q;
  logic signed [12:0] lead_phi_q;
  logic signed [15:0] lead_vz_q;
  logic [27:0]        plain_acc_q;
  logic [39:0]        mode_acc_q;
  logic [10:0]        count_acc_q;
  logic [15:0]        min_dr_q, min_drv_q;

  // Latched item.
  logic               op_q, last_q;
  logic signed [15:0] px_q, py_q, pz_q, vz_q;

  // Squarer products.
  logic [31:0] sxy_q, azsq_q, cnt_sq_q, cls_sq_q, lead_sq_q;
  logic [28:0] drsq_q;

  // Square root unit.
  logic [47:0] rt_v_q;
  logic [25:0] rt_rem_q;
  logic [23:0] rt_root_q;

  // Pseudorapidity setup.
  logic [23:0] b_q;
  logic [24:0] a_q;
  logic [25:0] bs_q;
  logic [5:0]  k_q;

  // CORDIC datapath.
  logic signed [27:0] cx_q, cy_q;
  logic signed [21:0] cz_q, eta_z_q;
  logic [4:0]         ci_q;
  logic               r4_q, r13_q;

  logic signed [13:0] eta_q;
  logic signed [12:0] phi_q;
  logic signed [14:0] deta_q;
  logic signed [13:0] dphi_q;
  logic [15:0]        dr_q;

  // Divider.
  logic [55:0] dv_q;
  logic [31:0] dv_rem_q, dv_den_q;
  logic        dv_sel_q;
  logic [39:0] rel_plain_q, rel_mode_q;

  // Output register.
  logic        out_valid_q;
  logic [39:0] out_sum_q;
  logic [10:0] out_count_q;
  logic [15:0] out_dr_q, out_drv_q;
  logic        out_iso_q;

  logic in_fire, out_free;
  assign in_fire  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;

  assign in_i.ready            = (state_q == ST_IDLE);
  assign out_o.valid           = out_valid_q;
  assign out_o.pt_sum          = out_sum_q;
  assign out_o.track_count     = out_count_q;
  assign out_o.closest_dr      = out_dr_q;
  assign out_o.closest_dr_veto = out_drv_q;
  assign out_o.isolated        = out_iso_q;

  // Magnitudes of the momentum components.
  logic [15:0] px_abs, py_abs, pz_abs;
  assign px_abs = px_q[15] ? 16'(-px_q) : 16'(px_q);
  assign py_abs = py_q[15] ? 16'(-py_q) : 16'(py_q);
  assign pz_abs = pz_q[15] ? 16'(-pz_q) : 16'(pz_q);

  logic [14:0] deta_abs;
  logic [13:0] dphi_abs;
  assign deta_abs = deta_q[14] ? 15'(-deta_q) : 15'(deta_q);
  assign dphi_abs = dphi_q[13] ? 14'(-dphi_q) : 14'(dphi_q);

  // Shared squarer, its operand chosen by the sequencer step.
  logic [15:0] sq_op;
  logic [31:0] sq;
  always_comb begin
    sq_op = lead_pt_q;
    if (state_q == ST_SQR) begin
      case (cnt_q)
        6'd0:    sq_op = px_abs;
        6'd1:    sq_op = py_abs;
        6'd2:    sq_op = pz_abs;
        6'd3:    sq_op = count_min_pt_q;
        6'd4:    sq_op = closest_min_pt_q;
        default: sq_op = lead_pt_q;
      endcase
    end else if (state_q == ST_DRSQ) begin
      sq_op = (cnt_q == 6'd0) ? {1'b0, deta_abs} : {2'b0, dphi_abs};
    end
  end
  assign sq = {16'b0, sq_op} * {16'b0, sq_op};

  // Square root step: two radicand bits per cycle.
  logic [27:0] rt_rem_sh, rt_trial;
  logic        rt_ge;
  logic [25:0] rt_rem_n;
  logic [23:0] rt_root_n;
  assign rt_rem_sh = {rt_rem_q, rt_v_q[47:46]};
  assign rt_trial  = {2'b00, rt_root_q, 2'b01};
  assign rt_ge     = (rt_rem_sh >= rt_trial);
  assign rt_rem_n  = rt_ge ? 26'(rt_rem_sh - rt_trial) : rt_rem_sh[25:0];
  assign rt_root_n = {rt_root_q[22:0], rt_ge};

  // Doubling search for the scale k of the hyperbolic argument.
  logic k_more;
  assign k_more = (b_q != 24'd0) && (k_q < tci_pkg::K_MAX) &&
                  ({bs_q, 1'b0} <= {2'b0, a_q});

  // CORDIC step, circular in ST_CIRC and hyperbolic in ST_HYP.
  logic               hyp;
  logic signed [27:0] c_dx, c_dy, cx_n, cy_n;
  logic signed [21:0] c_ang, cz_n;
  logic [4:0]         ci_hyp_n;
  logic               r4_n, r13_n;
  assign hyp   = (state_q == ST_HYP);
  assign c_dx  = cy_q >>> ci_q;
  assign c_dy  = cx_q >>> ci_q;
  assign c_ang = signed'({6'b0, hyp ? tci_pkg::atanh_lut(ci_q) : tci_pkg::atan_lut(ci_q)});
  always_comb begin
    if (cy_q > 28'sd0) begin
      cx_n = hyp ? cx_q - c_dx : cx_q + c_dx;
      cy_n = cy_q - c_dy;
      cz_n = cz_q + c_ang;
    end else begin
      cx_n = hyp ? cx_q + c_dx : cx_q - c_dx;
      cy_n = cy_q + c_dy;
      cz_n = cz_q - c_ang;
    end
    // Hyperbolic shifts 4 and 13 are taken twice for convergence.
    r4_n     = r4_q;
    r13_n    = r13_q;
    ci_hyp_n = ci_q;
    if (ci_q == 5'd4 && !r4_q) begin
      r4_n = 1'b1;
    end else if (ci_q == 5'd13 && !r13_q) begin
      r13_n = 1'b1;
    end else begin
      ci_hyp_n = ci_q + 5'd1;
    end
  end

  // Circular start: vector (px, py) scaled by 256, left half plane turned by pi.
  logic signed [27:0] cx_init, cy_init;
  logic signed [21:0] cz_init;
  always_comb begin
    cx_init = {{4{px_q[15]}}, px_q, 8'b0};
    cy_init = {{4{py_q[15]}}, py_q, 8'b0};
    cz_init = 22'sd0;
    if (px_q[15]) begin
      cx_init = -cx_init;
      cy_init = -cy_init;
      cz_init = py_q[15] ? -tci_pkg::PI_Z : tci_pkg::PI_Z;
    end
  end

  // Azimuth rounded to 1/1024; zero vector gives zero.
  logic signed [21:0] phi_sum;
  logic signed [12:0] phi_val;
  assign phi_sum = (cz_n + 22'sd32) >>> 6;
  assign phi_val = (px_q == 16'sd0 && py_q == 16'sd0) ? 13'sd0 : phi_sum[12:0];

  // Pseudorapidity: eta = 2z + k*ln2, rounded, clamped and signed by pz.
  logic [21:0]        k_ln2;
  logic signed [25:0] e_sum, e_sh, e_cl;
  logic signed [13:0] eta_val;
  assign k_ln2 = {16'b0, k_q} * {6'b0, tci_pkg::LN2_Z};
  assign e_sum = {{3{eta_z_q[21]}}, eta_z_q, 1'b0} + signed'({4'b0, k_ln2}) + 26'sd32;
  assign e_sh  = e_sum >>> 6;
  always_comb begin
    e_cl = e_sh;
    if (e_sh > tci_pkg::ETA_MAX) e_cl = tci_pkg::ETA_MAX;
    if (e_sh < -tci_pkg::ETA_MAX) e_cl = -tci_pkg::ETA_MAX;
    if (pz_q == 16'sd0) begin
      eta_val = 14'sd0;
    end else if (sxy_q == 32'd0) begin
      eta_val = pz_q[15] ? -14'sd8191 : 14'sd8191;
    end else begin
      eta_val = pz_q[15] ? -e_cl[13:0] : e_cl[13:0];
    end
  end

  // Vertex window and angular differences against the electron.
  logic signed [16:0] dz;
  logic               in_win;
  logic signed [13:0] dphi_raw, dphi_w1, dphi_w2;
  assign dz     = {vz_q[15], vz_q} - {lead_vz_q[15], lead_vz_q};
  assign in_win = (dz <= tci_pkg::VZ_WINDOW) && (dz >= -tci_pkg::VZ_WINDOW);
  assign dphi_raw = {phi_q[12], phi_q} - {lead_phi_q[12], lead_phi_q};
  assign dphi_w1  = (dphi_raw > tci_pkg::PHI_PI) ? dphi_raw - tci_pkg::PHI_2PI : dphi_raw;
  assign dphi_w2  = (dphi_w1 < -tci_pkg::PHI_PI) ? dphi_w1 + tci_pkg::PHI_2PI : dphi_w1;

  // Cone tests and accumulator updates.
  logic [15:0] trk_pt;
  logic        in_cone;
  logic [28:0] plain_add;
  logic [40:0] mode_add;
  assign trk_pt    = b_q[23:8];
  assign in_cone   = (dr_q < {3'b0, outer_radius_q}) && (dr_q > {3'b0, inner_radius_q});
  assign plain_add = {1'b0, plain_acc_q} + {13'b0, trk_pt};
  assign mode_add  = {1'b0, mode_acc_q} + {9'b0, sxy_q};

  // Divider: numerator and divisor setup, one restoring step per cycle.
  logic [55:0] dv_num;
  logic [31:0] dv_den;
  logic [32:0] dv_rem_sh;
  logic        dv_ge;
  logic [31:0] dv_rem_n;
  logic [55:0] dv_q_n;
  logic        div_done;
  logic [39:0] div_res;
  assign dv_num    = dv_sel_q ? {mode_acc_q, 16'b0} : {12'b0, plain_acc_q, 16'b0};
  assign dv_den    = dv_sel_q ? lead_sq_q : {16'b0, lead_pt_q};
  assign dv_rem_sh = {dv_rem_q, dv_q[55]};
  assign dv_ge     = (dv_rem_sh >= {1'b0, dv_den_q});
  assign dv_rem_n  = dv_ge ? 32'(dv_rem_sh - {1'b0, dv_den_q}) : dv_rem_sh[31:0];
  assign dv_q_n    = {dv_q[54:0], dv_ge};
  assign div_done  = ((state_q == ST_DSET) && (dv_den == 32'd0)) ||
                     ((state_q == ST_DIV) && (cnt_q == tci_pkg::DIV_LAST));
  always_comb begin
    if (state_q == ST_DSET) begin
      // A zero electron pt saturates any nonzero relative sum.
      div_res = (dv_num != 56'd0) ? tci_pkg::SAT40 : 40'd0;
    end else begin
      div_res = (dv_q_n[55:40] != 16'd0) ? tci_pkg::SAT40 : dv_q_n[39:0];
    end
  end

  // Result selection per sum mode.
  logic [39:0] sum_sel;
  always_comb begin
    case (sum_mode_q)
      tci_pkg::MODE_PLAIN:  sum_sel = {12'b0, plain_acc_q};
      tci_pkg::MODE_REL:    sum_sel = rel_plain_q;
      tci_pkg::MODE_SQ:     sum_sel = mode_acc_q;
      tci_pkg::MODE_REL_SQ: sum_sel = rel_mode_q;
      default:              sum_sel = {12'b0, plain_acc_q};
    endcase
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q + 6'd1;
    case (state_q)
      ST_IDLE: begin
        cnt_d = 6'd0;
        if (in_fire) state_d = ST_SQR;
      end
      ST_SQR: begin
        if (cnt_q == tci_pkg::SQ_LAST) begin
          state_d = ST_ROOT_B;
          cnt_d   = 6'd0;
        end
      end
      ST_ROOT_B: begin
        if (cnt_q == tci_pkg::ROOT_LAST) begin
          state_d = ST_ROOT_A;
          cnt_d   = 6'd0;
        end
      end
      ST_ROOT_A: begin
        if (cnt_q == tci_pkg::ROOT_LAST) begin
          state_d = ST_KSRCH;
          cnt_d   = 6'd0;
        end
      end
      ST_KSRCH: begin
        cnt_d = 6'd0;
        if (!k_more) state_d = ST_HYP;
      end
      ST_HYP: begin
        if (cnt_q == tci_pkg::CORDIC_LAST) begin
          state_d = ST_CIRC;
          cnt_d   = 6'd0;
        end
      end
      ST_CIRC: begin
        if (cnt_q == tci_pkg::CORDIC_LAST) begin
          state_d = ST_ETA;
          cnt_d   = 6'd0;
        end
      end
      ST_ETA: begin
        state_d = ST_CMP;
        cnt_d   = 6'd0;
      end
      ST_CMP: begin
        cnt_d = 6'd0;
        if (!op_q) begin
          state_d = ST_IDLE;
        end else if (in_win) begin
          state_d = ST_DRSQ;
        end else if (last_q) begin
          state_d = ST_DSET;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_DRSQ: begin
        if (cnt_q == tci_pkg::DRSQ_LAST) begin
          state_d = ST_ROOT_DR;
          cnt_d   = 6'd0;
        end
      end
      ST_ROOT_DR: begin
        if (cnt_q == tci_pkg::ROOT_LAST) begin
          state_d = ST_ACC;
          cnt_d   = 6'd0;
        end
      end
      ST_ACC: begin
        cnt_d   = 6'd0;
        state_d = last_q ? ST_DSET : ST_IDLE;
      end
      ST_DSET: begin
        cnt_d   = 6'd0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
      end
      ST_OUT: begin
        cnt_d = 6'd0;
        if (out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
        cnt_d   = 6'd0;
      end
    endcase
    // After the plain relative sum, relative squared mode runs a second division.
    if (div_done) begin
      cnt_d   = 6'd0;
      state_d = (!dv_sel_q && sum_mode_q == tci_pkg::MODE_REL_SQ) ? ST_DSET : ST_OUT;
    end
  end

  // Control, configuration, electron and accumulator registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= ST_IDLE;
      cnt_q            <= 6'd0;
      sum_mode_q       <= 2'd0;
      outer_radius_q   <= 13'd205;
      inner_radius_q   <= 13'd15;
      count_min_pt_q   <= 16'd64;
      closest_min_pt_q <= 16'd64;
      iso_threshold_q  <= 16'd3277;
      lead_pt_q        <= 16'd0;
      lead_eta_q       <= 14'sd0;
      lead_phi_q       <= 13'sd0;
      lead_vz_q        <= 16'sd0;
      plain_acc_q      <= 28'd0;
      mode_acc_q       <= 40'd0;
      count_acc_q      <= 11'd0;
      min_dr_q         <= tci_pkg::NO_DR;
      min_drv_q        <= tci_pkg::NO_DR;
      out_valid_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;

      if (cfg_we_i) begin
        case (cfg_idx_i)
          tci_pkg::REG_SUM_MODE:       sum_mode_q       <= cfg_wdata_i[1:0];
          tci_pkg::REG_OUTER_RADIUS:   outer_radius_q   <= cfg_wdata_i[12:0];
          tci_pkg::REG_INNER_RADIUS:   inner_radius_q   <= cfg_wdata_i[12:0];
          tci_pkg::REG_COUNT_MIN_PT:   count_min_pt_q   <= cfg_wdata_i;
          tci_pkg::REG_CLOSEST_MIN_PT: closest_min_pt_q <= cfg_wdata_i;
          tci_pkg::REG_ISO_THRESHOLD:  iso_threshold_q  <= cfg_wdata_i;
          default: begin
          end
        endcase
      end

      if (state_q == ST_CMP && !op_q) begin
        // An electron opens a new event.
        lead_pt_q   <= trk_pt;
        lead_eta_q  <= eta_q;
        lead_phi_q  <= phi_q;
        lead_vz_q   <= vz_q;
        plain_acc_q <= 28'd0;
        mode_acc_q  <= 40'd0;
        count_acc_q <= 11'd0;
        min_dr_q    <= tci_pkg::NO_DR;
        min_drv_q   <= tci_pkg::NO_DR;
      end else if (state_q == ST_ACC) begin
        if (in_cone && sxy_q >= tci_pkg::MIN_SUM_SQ) begin
          plain_acc_q <= plain_add[28] ? tci_pkg::SAT28 : plain_add[27:0];
          mode_acc_q  <= mode_add[40] ? tci_pkg::SAT40 : mode_add[39:0];
        end
        if (in_cone && sxy_q >= cnt_sq_q && count_acc_q < tci_pkg::COUNT_CAP) begin
          count_acc_q <= count_acc_q + 11'd1;
        end
        if (sxy_q >= cls_sq_q) begin
          if (dr_q < min_dr_q) min_dr_q <= dr_q;
          if (dr_q > {3'b0, inner_radius_q} && dr_q < min_drv_q) min_drv_q <= dr_q;
        end
      end else if (state_q == ST_OUT && out_free) begin
        plain_acc_q <= 28'd0;
        mode_acc_q  <= 40'd0;
        count_acc_q <= 11'd0;
        min_dr_q    <= tci_pkg::NO_DR;
        min_drv_q   <= tci_pkg::NO_DR;
      end

      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          op_q   <= in_i.operation;
          px_q   <= in_i.mom_x;
          py_q   <= in_i.mom_y;
          pz_q   <= in_i.mom_z;
          vz_q   <= in_i.vertex_z;
          last_q <= in_i.last;
        end
      end
      ST_SQR: begin
        case (cnt_q)
          6'd0:    sxy_q     <= sq;
          6'd1:    sxy_q     <= sxy_q + sq;
          6'd2:    azsq_q    <= sq;
          6'd3:    cnt_sq_q  <= sq;
          6'd4:    cls_sq_q  <= sq;
          default: lead_sq_q <= sq;
        endcase
        if (cnt_q == tci_pkg::SQ_LAST) begin
          rt_v_q    <= {sxy_q, 16'b0};
          rt_rem_q  <= 26'd0;
          rt_root_q <= 24'd0;
        end
      end
      ST_ROOT_B: begin
        if (cnt_q == tci_pkg::ROOT_LAST) begin
          b_q       <= rt_root_n;
          rt_v_q    <= {sxy_q + azsq_q, 16'b0};
          rt_rem_q  <= 26'd0;
          rt_root_q <= 24'd0;
        end else begin
          rt_v_q    <= {rt_v_q[45:0], 2'b00};
          rt_rem_q  <= rt_rem_n;
          rt_root_q <= rt_root_n;
        end
      end
      ST_ROOT_A: begin
        rt_v_q    <= {rt_v_q[45:0], 2'b00};
        rt_rem_q  <= rt_rem_n;
        rt_root_q <= rt_root_n;
        if (cnt_q == tci_pkg::ROOT_LAST) begin
          a_q  <= {1'b0, rt_root_n} + {1'b0, pz_abs, 8'b0};
          bs_q <= {2'b0, b_q};
          k_q  <= 6'd0;
        end
      end
      ST_KSRCH: begin
        if (k_more) begin
          bs_q <= {bs_q[24:0], 1'b0};
          k_q  <= k_q + 6'd1;
        end else begin
          cx_q  <= signed'({3'b0, a_q} + {2'b0, bs_q});
          cy_q  <= signed'({3'b0, a_q} - {2'b0, bs_q});
          cz_q  <= 22'sd0;
          ci_q  <= 5'd1;
          r4_q  <= 1'b0;
          r13_q <= 1'b0;
        end
      end
      ST_HYP: begin
        if (cnt_q == tci_pkg::CORDIC_LAST) begin
          eta_z_q <= cz_n;
          cx_q    <= cx_init;
          cy_q    <= cy_init;
          cz_q    <= cz_init;
          ci_q    <= 5'd0;
        end else begin
          cx_q  <= cx_n;
          cy_q  <= cy_n;
          cz_q  <= cz_n;
          ci_q  <= ci_hyp_n;
          r4_q  <= r4_n;
          r13_q <= r13_n;
        end
      end
      ST_CIRC: begin
        cx_q <= cx_n;
        cy_q <= cy_n;
        cz_q <= cz_n;
        ci_q <= ci_q + 5'd1;
        if (cnt_q == tci_pkg::CORDIC_LAST) phi_q <= phi_val;
      end
      ST_ETA: begin
        eta_q <= eta_val;
      end
      ST_CMP: begin
        deta_q   <= {eta_q[13], eta_q} - {lead_eta_q[13], lead_eta_q};
        dphi_q   <= dphi_w2;
        dv_sel_q <= 1'b0;
      end
      ST_DRSQ: begin
        if (cnt_q == 6'd0) begin
          drsq_q <= sq[28:0];
        end else begin
          rt_v_q    <= {19'b0, drsq_q + sq[28:0]};
          rt_rem_q  <= 26'd0;
          rt_root_q <= 24'd0;
        end
      end
      ST_ROOT_DR: begin
        rt_v_q    <= {rt_v_q[45:0], 2'b00};
        rt_rem_q  <= rt_rem_n;
        rt_root_q <= rt_root_n;
        if (cnt_q == tci_pkg::ROOT_LAST) dr_q <= rt_root_n[15:0];
      end
      ST_ACC: begin
        dv_sel_q <= 1'b0;
      end
      ST_DSET: begin
        dv_q     <= dv_num;
        dv_rem_q <= 32'd0;
        dv_den_q <= dv_den;
      end
      ST_DIV: begin
        dv_q     <= dv_q_n;
        dv_rem_q <= dv_rem_n;
      end
      ST_OUT: begin
        if (out_free) begin
          out_sum_q   <= sum_sel;
          out_count_q <= count_acc_q;
          out_dr_q    <= min_dr_q;
          out_drv_q   <= min_drv_q;
          out_iso_q   <= (rel_plain_q <= {24'b0, iso_threshold_q});
        end
      end
      default: begin
      end
    endcase

    if (div_done) begin
      if (!dv_sel_q) begin
        rel_plain_q <= div_res;
        dv_sel_q    <= 1'b1;
      end else begin
        rel_mode_q  <= div_res;
      end
    end
  end

endmodule

// ----- sim/tci_isolation_checker.sv -----
// ----------------------------------------------------------------------------
// tci_isolation_checker: result predictor and scoreboard for the cone block
// Watches the track and result channels and the register write port. It works
// out the isolation result for each event, keeps the results still to come in
// arrival order and compares every transfer on the result channel field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tci_isolation_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [tci_pkg::IDX_W-1:0]   cfg_idx_i,
  input  logic [tci_pkg::CFG_W-1:0]   cfg_wdata_i,
  tci_in_if                           trk_mon,
  tci_out_if                          iso_mon,
  output int                          fail_count_o,
  output int                          results_due_o
);

  typedef struct packed {
    logic [tci_pkg::SUM_W-1:0] pt_sum;
    logic [tci_pkg::CNT_W-1:0] track_count;
    logic [tci_pkg::DR_W-1:0]  closest_dr;
    logic [tci_pkg::DR_W-1:0]  closest_dr_veto;
    logic                      isolated;
  } iso_result_t;

  localparam longint CIRC_PI  = 205887;
  localparam longint LOG_TWO  = 45426;
  localparam int     HALF_TURN = 3217;
  localparam int     FULL_TURN = 6434;
  localparam int     ETA_LIMIT = 8191;
  localparam int     DZ_WINDOW = 51;
  localparam longint unsigned SUM_PT_CUT_SQ = 4096;
  localparam longint unsigned SUM40_MAX = 64'hFF_FFFF_FFFF;
  localparam longint unsigned SUM28_MAX = 64'hFFF_FFFF;

  localparam longint ATAN_Z [0:23] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024,
    512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0};
  localparam longint ATANH_Z [0:31] = '{0, 35999, 16739, 8235, 4101, 2049, 1024,
    512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
    0, 0};

  // Register copies.
  logic [1:0]  mode_q;
  logic [12:0] outer_q, inner_q;
  logic [15:0] cnt_pt_q, near_pt_q, iso_lim_q;
  // Electron and running event sums.
  longint unsigned e_pt;
  int              e_eta, e_phi, e_vz;
  longint unsigned sq_sum, pt_sum_acc;
  int unsigned     n_in_cone, dr_min, dr_min_veto;

  iso_result_t results_due_q[$];

  function automatic longint unsigned int_root(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Azimuth in 1/1024 rad by circular vectoring.
  function automatic int azimuth(input int px, input int py);
    longint x, y, z, dx, dy;
    x = longint'(px) * 256;
    y = longint'(py) * 256;
    z = 0;
    if (px == 0 && py == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? CIRC_PI : -CIRC_PI;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < tci_pkg::CORDIC_STEPS && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += ATAN_Z[i];
      end else begin
        x -= dx; y += dy; z -= ATAN_Z[i];
      end
    end
    return int'((z + 32) >>> 6);
  endfunction

  // Pseudorapidity: range reduction by powers of two, then hyperbolic vectoring
  // with the usual repeats at shifts 4 and 13.
  function automatic int pseudorapidity(input longint unsigned sxy, input int pz);
    longint unsigned az, a, b, bs;
    longint x, y, z, e, dx, dy;
    int k, sh;
    bit rep4, rep13;
    az = (pz < 0) ? longint'(-pz) : longint'(pz);
    z = 0; k = 0; sh = 1; rep4 = 0; rep13 = 0;
    if (pz == 0) return 0;
    if (sxy == 0) return (pz > 0) ? ETA_LIMIT : -ETA_LIMIT;
    b = int_root(sxy << 16);
    a = int_root((sxy + az * az) << 16) + (az << 8);
    while (k < 40 && (b << (k + 1)) <= a) k++;
    bs = b << k;
    x = longint'(a + bs);
    y = longint'(a - bs);
    for (int n = 0; n < tci_pkg::CORDIC_STEPS; n++) begin
      dx = y >>> (sh & 31);
      dy = x >>> (sh & 31);
      if (y > 0) begin
        x -= dx; y -= dy; z += ATANH_Z[sh & 31];
      end else begin
        x += dx; y += dy; z -= ATANH_Z[sh & 31];
      end
      if (sh == 4 && !rep4) rep4 = 1;
      else if (sh == 13 && !rep13) rep13 = 1;
      else sh++;
    end
    e = (2 * z + longint'(k) * LOG_TWO + 32) >>> 6;
    if (e > ETA_LIMIT) e = ETA_LIMIT;
    if (e < -ETA_LIMIT) e = -ETA_LIMIT;
    return (pz < 0) ? -int'(e) : int'(e);
  endfunction

  function automatic longint unsigned scaled_ratio(input longint unsigned num,
                                                   input longint unsigned den);
    longint unsigned q;
    if (den == 0) return (num != 0) ? SUM40_MAX : 0;
    q = (num << 16) / den;
    return (q > SUM40_MAX) ? SUM40_MAX : q;
  endfunction

  task automatic clear_event();
    sq_sum = 0;
    pt_sum_acc = 0;
    n_in_cone = 0;
    dr_min = tci_pkg::NO_DR;
    dr_min_veto = tci_pkg::NO_DR;
  endtask

  // Folds one accepted item into the event and queues a result on a last track.
  task automatic absorb_item();
    int px, py, pz, vz, eta, phi, dz, deta, dphi;
    longint unsigned sxy, pt, dr, rel_plain, total;
    bit in_cone;
    iso_result_t r;
    px = int'(trk_mon.mom_x);
    py = int'(trk_mon.mom_y);
    pz = int'(trk_mon.mom_z);
    vz = int'(trk_mon.vertex_z);
    sxy = longint'(px * px) + longint'(py * py);
    pt = int_root(sxy);
    eta = pseudorapidity(sxy, pz);
    phi = azimuth(px, py);
    if (trk_mon.operation == 1'b0) begin
      e_pt = pt; e_eta = eta; e_phi = phi; e_vz = vz;
      clear_event();
      return;
    end
    dz = vz - e_vz;
    if (dz <= DZ_WINDOW && dz >= -DZ_WINDOW) begin
      deta = eta - e_eta;
      dphi = phi - e_phi;
      if (dphi > HALF_TURN) dphi -= FULL_TURN;
      if (dphi < -HALF_TURN) dphi += FULL_TURN;
      dr = int_root(longint'(deta) * deta + longint'(dphi) * dphi);
      in_cone = (dr < outer_q) && (dr > inner_q);
      if (in_cone && sxy >= SUM_PT_CUT_SQ) begin
        pt_sum_acc += pt;
        if (pt_sum_acc > SUM28_MAX) pt_sum_acc = SUM28_MAX;
        sq_sum += sxy;
        if (sq_sum > SUM40_MAX) sq_sum = SUM40_MAX;
      end
      if (in_cone && sxy >= longint'(cnt_pt_q) * cnt_pt_q &&
          n_in_cone < tci_pkg::COUNT_CAP_I)
        n_in_cone++;
      if (sxy >= longint'(near_pt_q) * near_pt_q) begin
        if (dr < dr_min) dr_min = 32'(dr);
        if (dr > inner_q && dr < dr_min_veto) dr_min_veto = 32'(dr);
      end
    end
    if (trk_mon.last == 1'b0) return;
    rel_plain = scaled_ratio(pt_sum_acc, e_pt);
    total = mode_q[1] ? sq_sum : pt_sum_acc;
    if (mode_q[0]) total = scaled_ratio(total, mode_q[1] ? e_pt * e_pt : e_pt);
    r.pt_sum = total[tci_pkg::SUM_W-1:0];
    r.track_count = n_in_cone[tci_pkg::CNT_W-1:0];
    r.closest_dr = dr_min[tci_pkg::DR_W-1:0];
    r.closest_dr_veto = dr_min_veto[tci_pkg::DR_W-1:0];
    r.isolated = (rel_plain <= iso_lim_q);
    results_due_q.push_back(r);
    clear_event();
  endtask

  task automatic check_result();
    iso_result_t want;
    if (results_due_q.size() == 0) begin
      $display("%0t: unexpected result, sum %0d count %0d", $time,
               iso_mon.pt_sum, iso_mon.track_count);
      fail_count_o++;
      return;
    end
    want = results_due_q.pop_front();
    if (iso_mon.pt_sum !== want.pt_sum) begin
      $display("%0t: pt_sum expected %0d got %0d", $time, want.pt_sum, iso_mon.pt_sum);
      fail_count_o++;
    end
    if (iso_mon.track_count !== want.track_count) begin
      $display("%0t: track_count expected %0d got %0d", $time, want.track_count,
               iso_mon.track_count);
      fail_count_o++;
    end
    if (iso_mon.closest_dr !== want.closest_dr) begin
      $display("%0t: closest_dr expected %0d got %0d", $time, want.closest_dr,
               iso_mon.closest_dr);
      fail_count_o++;
    end
    if (iso_mon.closest_dr_veto !== want.closest_dr_veto) begin
      $display("%0t: closest_dr_veto expected %0d got %0d", $time,
               want.closest_dr_veto, iso_mon.closest_dr_veto);
      fail_count_o++;
    end
    if (iso_mon.isolated !== want.isolated) begin
      $display("%0t: isolated expected %0b got %0b", $time, want.isolated,
               iso_mon.isolated);
      fail_count_o++;
    end
  endtask

  initial begin
    fail_count_o = 0;
    results_due_o = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q = tci_pkg::MODE_PLAIN;
      outer_q = 13'd205;
      inner_q = 13'd15;
      cnt_pt_q = 16'd64;
      near_pt_q = 16'd64;
      iso_lim_q = 16'd3277;
      e_pt = 0; e_eta = 0; e_phi = 0; e_vz = 0;
      clear_event();
      results_due_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          tci_pkg::REG_SUM_MODE:       mode_q = cfg_wdata_i[1:0];
          tci_pkg::REG_OUTER_RADIUS:   outer_q = cfg_wdata_i[12:0];
          tci_pkg::REG_INNER_RADIUS:   inner_q = cfg_wdata_i[12:0];
          tci_pkg::REG_COUNT_MIN_PT:   cnt_pt_q = cfg_wdata_i;
          tci_pkg::REG_CLOSEST_MIN_PT: near_pt_q = cfg_wdata_i;
          tci_pkg::REG_ISO_THRESHOLD:  iso_lim_q = cfg_wdata_i;
          default: ;
        endcase
      end
      if (trk_mon.valid === 1'b1 && trk_mon.ready === 1'b1) absorb_item();
      if (iso_mon.valid === 1'b1 && iso_mon.ready === 1'b1) check_result();
    end
    results_due_o = results_due_q.size();
  end

endmodule

// ----- sim/tb_track_cone_isolation_core.sv -----
// ----------------------------------------------------------------------------
// tb_track_cone_isolation_core: top level of the cone isolation testbench
// Drives electron and track items with random idle and stall patterns, moves
// the block through several register settings and reports the verdict from
// the checker's failure count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_track_cone_isolation_core;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we;
  logic [tci_pkg::IDX_W-1:0]    cfg_idx;
  logic [tci_pkg::CFG_W-1:0]    cfg_wdata;
  int                           fail_count;
  int                           results_due;

  // Idle percentages for the sender and the receiver in the current phase.
  int unsigned tx_idle_pct;
  int unsigned rx_stall_pct;
  // The long receiver hold-off is requested by the stimulus and timed in its
  // own process below.
  bit hold_go;
  bit hold_active;

  tci_in_if  trk_ch ();
  tci_out_if iso_ch ();

  track_cone_isolation_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (trk_ch),
    .out_o       (iso_ch)
  );

  tci_isolation_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .trk_mon       (trk_ch),
    .iso_mon       (iso_ch),
    .fail_count_o  (fail_count),
    .results_due_o (results_due)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Every input starts at a known value before the first edge.
  initial begin
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = tci_pkg::REG_SUM_MODE;
    cfg_wdata = '0;
    trk_ch.valid = 1'b0;
    trk_ch.operation = 1'b0;
    trk_ch.mom_x = '0;
    trk_ch.mom_y = '0;
    trk_ch.mom_z = '0;
    trk_ch.vertex_z = '0;
    trk_ch.last = 1'b0;
    iso_ch.ready = 1'b0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    hold_go = 1'b0;
    hold_active = 1'b0;
  end

  // Receiver: random stalls, forced low during a hold-off.
  always @(posedge clk_i) begin
    if (hold_active) begin
      iso_ch.ready <= 1'b0;
    end else begin
      iso_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Long hold-off: ready stays low so that the block fills up and stops
  // taking tracks while the sender keeps offering them.
  initial begin
    forever begin
      wait (hold_go);
      @(negedge clk_i);
      hold_active = 1'b1;
      repeat (2000) @(negedge clk_i);
      hold_active = 1'b0;
      hold_go = 1'b0;
    end
  end

  // Saturates a computed momentum or vertex value to the 16-bit field range.
  function automatic logic signed [15:0] clip16(input int v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  // Offers one item and returns at the edge where the transfer takes place.
  // Ready is looked at on the falling edge so no sample races the block.
  task automatic send_item(input logic op, input int px, input int py, input int pz,
                           input int vz, input logic lst);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      trk_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    trk_ch.valid <= 1'b1;
    trk_ch.operation <= op;
    trk_ch.mom_x <= clip16(px);
    trk_ch.mom_y <= clip16(py);
    trk_ch.mom_z <= clip16(pz);
    trk_ch.vertex_z <= clip16(vz);
    trk_ch.last <= lst;
    @(negedge clk_i);
    while (trk_ch.ready !== 1'b1) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // Stops offering items and waits until every expected result has come, then
  // lets the block finish any track that produces no result.
  task automatic drain();
    trk_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (results_due != 0) @(negedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  // Writes all six registers on consecutive edges; only called while idle.
  task automatic write_regs(input int unsigned mode, input int unsigned outer_r,
                            input int unsigned inner_r, input int unsigned cnt_pt,
                            input int unsigned near_pt, input int unsigned iso_lim);
    logic [tci_pkg::IDX_W-1:0] idx_list [6];
    int unsigned               val_list [6];
    idx_list = '{tci_pkg::REG_SUM_MODE, tci_pkg::REG_OUTER_RADIUS,
                 tci_pkg::REG_INNER_RADIUS, tci_pkg::REG_COUNT_MIN_PT,
                 tci_pkg::REG_CLOSEST_MIN_PT, tci_pkg::REG_ISO_THRESHOLD};
    val_list = '{mode, outer_r, inner_r, cnt_pt, near_pt, iso_lim};
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1'b1;
      cfg_idx <= idx_list[i];
      cfg_wdata <= val_list[i][tci_pkg::CFG_W-1:0];
      @(posedge clk_i);
    end
    cfg_we <= 1'b0;
  endtask

  // Random traffic: mostly well-formed events (an electron then a few tracks
  // pointing close to it from a nearby vertex), with some pure noise items.
  task automatic random_events(input int n_items, input bit pause_midway);
    int sent, ex, ey, ez, ev, ntr, f, nz;
    bit paused;
    sent = 0;
    paused = 1'b0;
    while (sent < n_items) begin
      if (pause_midway && !paused && sent >= n_items / 2) begin
        drain();
        paused = 1'b1;
      end
      if ($urandom_range(99) < 15) begin
        send_item(1'($urandom_range(1)), $signed(16'($urandom)), $signed(16'($urandom)),
                  $signed(16'($urandom)), $signed(16'($urandom)),
                  1'($urandom_range(1)));
        sent++;
      end else begin
        ex = int'($urandom_range(16000)) - 8000;
        ey = int'($urandom_range(16000)) - 8000;
        ez = int'($urandom_range(32000)) - 16000;
        ev = int'($urandom_range(65535)) - 32768;
        if ($urandom_range(9) == 0) begin
          ex = ex / 64;
          ey = ey / 64;
        end
        send_item(1'b0, ex, ey, ez, ev, 1'($urandom_range(1)));
        sent++;
        ntr = $urandom_range(1, 8);
        for (int t = 0; t < ntr; t++) begin
          f = $urandom_range(1, 16);
          nz = ($urandom_range(3) == 0) ? 3000 : 300;
          send_item(1'b1, ex * f / 8 + int'($urandom_range(2 * nz)) - nz,
                    ey * f / 8 + int'($urandom_range(2 * nz)) - nz,
                    ez * f / 8 + int'($urandom_range(2 * nz)) - nz,
                    ev + int'($urandom_range(120)) - 60, t == ntr - 1);
          sent++;
        end
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset settings, no idling on either side.
    // Tracks before any electron are compared with the all-zero electron.
    send_item(1'b1, 1000, 0, 0, 0, 1'b0);
    send_item(1'b1, 0, 0, 0, 0, 1'b1);
    // An electron ignores its last flag; extreme momenta follow.
    send_item(1'b0, 32767, -32768, 32767, 32767, 1'b1);
    send_item(1'b1, -32768, -32768, -32768, 32767, 1'b0);
    send_item(1'b1, 30000, -30000, 30000, 32700, 1'b0);
    // Zero transverse momentum with positive and negative longitudinal momentum.
    send_item(1'b1, 0, 0, 500, 32767, 1'b0);
    send_item(1'b1, 0, 0, -500, 32767, 1'b1);
    // Zero electron pt: relative results saturate when the sum is nonzero.
    send_item(1'b0, 0, 0, 0, 0, 1'b0);
    send_item(1'b1, 100, 50, 0, 0, 1'b0);
    send_item(1'b1, 200, -10, 30, 10, 1'b1);
    // Vertex window edges and a new sum after the last track.
    send_item(1'b0, -3000, 10, 2000, -32768, 1'b0);
    send_item(1'b1, -3000, -10, 2000, -32717, 1'b0);
    send_item(1'b1, -3000, 20, 2100, -32716, 1'b0);
    send_item(1'b1, -2990, 0, 1990, -32768, 1'b1);
    send_item(1'b1, -3000, 5, 2000, -32768, 1'b1);
    send_item(1'b0, 2000, 2000, 0, 100, 1'b0);
    send_item(1'b1, 2010, 1990, 0, 151, 1'b0);
    send_item(1'b1, 2040, 1960, 10, 49, 1'b1);
    random_events(120, 1'b0);
    drain();

    // Relative plain sum, widest cone, no cuts, loosest threshold.
    write_regs(tci_pkg::MODE_REL, 8191, 0, 0, 0, 65535);
    tx_idle_pct = 47;
    random_events(130, 1'b0);
    drain();

    // Squared sum with an empty cone and the highest cuts.
    write_regs(tci_pkg::MODE_SQ, 0, 8191, 65535, 65535, 0);
    tx_idle_pct = 0;
    rx_stall_pct = 47;
    random_events(130, 1'b0);
    drain();

    // Relative squared sum; the sender pauses halfway for all results.
    write_regs(tci_pkg::MODE_REL_SQ, 300, 10, 128, 32, 6000);
    tx_idle_pct = 37;
    rx_stall_pct = 37;
    random_events(130, 1'b1);
    drain();

    // Reset-like settings with the long receiver hold-off.
    write_regs(tci_pkg::MODE_PLAIN, 205, 15, 64, 64, 3277);
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    hold_go = 1'b1;
    random_events(130, 1'b0);
    drain();

    write_regs(tci_pkg::MODE_REL_SQ, 1000, 100, 6000, 500, 20000);
    tx_idle_pct = 47;
    rx_stall_pct = 47;
    random_events(130, 1'b0);
    drain();

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Generous overall limit: far above the slowest correct run.
  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
design/tci_pkg.sv
design/tci_if.sv
design/track_cone_isolation_core.sv
sim/tci_isolation_checker.sv
sim/tb_track_cone_isolation_core.sv
